// File: hdl/tag_pose_to_world_error_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tag pose to world block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TAG_POSE_TO_WORLD_ERROR_ASSERT_SVH
`define TAG_POSE_TO_WORLD_ERROR_ASSERT_SVH

`ifndef SYNTHESIS
// expr must hold at every edge outside reset
`define TPW_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// cause in one cycle implies effect in the next
`define TPW_ASSERT_NEXT(lbl, clk, rst, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("assertion failed");
`else
`define TPW_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TPW_ASSERT_NEXT(lbl, clk, rst, cause, effect)
`endif

`endif

// File: hdl/tpw_pkg.sv
// ---------------------------------------------------------------------------
// tpw_pkg
// Shared widths, codes and helpers of the tag pose to world block.
// ---------------------------------------------------------------------------
package tpw_pkg;

  localparam int QW    = 16;  // quaternion component
  localparam int PW    = 32;  // Q16.16 position
  localparam int MW    = 34;  // rotation matrix entry, Q6.28 scaled by |q|^2
  localparam int BW    = 17;  // multiplier narrow operand
  localparam int PRW   = MW + BW;
  localparam int ACCW  = 70;  // numerator accumulator
  localparam int NW    = 33;  // |q|^2
  localparam int RW    = 42;  // rotated coordinate after clamp
  localparam int EW    = 31;  // error field
  localparam int NPROD = 10;

  // quaternion product slots
  localparam logic [3:0] P_WW = 4'd0;
  localparam logic [3:0] P_II = 4'd1;
  localparam logic [3:0] P_JJ = 4'd2;
  localparam logic [3:0] P_KK = 4'd3;
  localparam logic [3:0] P_IJ = 4'd4;
  localparam logic [3:0] P_IK = 4'd5;
  localparam logic [3:0] P_JK = 4'd6;
  localparam logic [3:0] P_WI = 4'd7;
  localparam logic [3:0] P_WJ = 4'd8;
  localparam logic [3:0] P_WK = 4'd9;

  // configuration register indexes
  localparam logic [1:0] REG_WALL   = 2'd0;
  localparam logic [1:0] REG_DEPTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [31:0] WALL_RESET   = 32'd196608;
  localparam logic [31:0] DEPTH_RESET  = 32'd7209;
  localparam logic [31:0] HEIGHT_RESET = 32'd196608;

  typedef struct packed {
    logic issue;  // product goes to the accumulator
    logic clr;    // first term of a sum
    logic shl;    // product weighs 2^16
  } mac_ctl_t;

  // saturate a 43-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic [42:0] v);
    logic [31:0] r;
    if (v[42:31] == {12{v[42]}}) begin
      r = v[31:0];
    end else if (v[42]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // absolute value of a 33-bit signed difference, saturated to 31 bits
  function automatic logic [EW-1:0] abs_sat(input logic [32:0] d);
    logic [32:0] m;
    logic [EW-1:0] r;
    m = d[32] ? (33'd0 - d) : d;
    if (m[32:31] != 2'b00) begin
      r = {EW{1'b1}};
    end else begin
      r = m[EW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/tpw_mac.sv
// ---------------------------------------------------------------------------
// tpw_mac
// Shared 34x17 signed multiplier with a registered product and accumulator.
// ---------------------------------------------------------------------------
module tpw_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  tpw_pkg::mac_ctl_t                 ctl,
  input  logic signed [tpw_pkg::MW-1:0]     a,
  input  logic signed [tpw_pkg::BW-1:0]     b,
  output logic signed [tpw_pkg::PRW-1:0]    prod,
  output logic signed [tpw_pkg::ACCW-1:0]   acc
);

  tpw_pkg::mac_ctl_t            ctl_q;
  logic signed [tpw_pkg::ACCW-1:0] addend;
  logic signed [tpw_pkg::ACCW-1:0] base;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    if (ctl_q.shl) begin
      addend = {{(tpw_pkg::ACCW-tpw_pkg::PRW-16){prod[tpw_pkg::PRW-1]}}, prod, 16'd0};
    end else begin
      addend = {{(tpw_pkg::ACCW-tpw_pkg::PRW){prod[tpw_pkg::PRW-1]}}, prod};
    end
    base = ctl_q.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
    if (ctl_q.issue) begin
      acc <= base + addend;
    end
  end

endmodule

// File: hdl/tpw_div.sv
// ---------------------------------------------------------------------------
// tpw_div
// Restoring divider, one quotient bit a cycle, rounds half away from zero.
// ---------------------------------------------------------------------------
module tpw_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [tpw_pkg::ACCW-1:0]  num,
  input  logic [tpw_pkg::NW-1:0]           den,
  output logic                             done,
  output logic signed [tpw_pkg::RW-1:0]    quo
);

  localparam logic [6:0] STEPS = 7'(tpw_pkg::ACCW);
  localparam logic [40:0] QMAX = 41'h100_0000_0000;

  logic                          run;
  logic [6:0]                    cnt;
  logic                          neg;
  logic [tpw_pkg::ACCW-1:0]      sh;
  logic [tpw_pkg::NW-1:0]        rem;
  logic [tpw_pkg::NW-1:0]        dvs;
  logic [tpw_pkg::ACCW-1:0]      mag;
  logic [tpw_pkg::NW:0]          trial;
  logic                          fits;
  logic [40:0]                   qmag;

  always_comb begin
    mag   = num[tpw_pkg::ACCW-1] ? ('0 - num) : num;
    trial = {rem, sh[tpw_pkg::ACCW-1]};
    fits  = (trial >= {1'b0, dvs});
    // clamp the magnitude to 2^40
    if (sh[tpw_pkg::ACCW-1:41] != '0 || sh[40:0] > QMAX) begin
      qmag = QMAX;
    end else begin
      qmag = sh[40:0];
    end
    quo = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 7'd1);
      if (start) begin
        run <= 1'b1;
        cnt <= STEPS;
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      neg <= num[tpw_pkg::ACCW-1];
      sh  <= mag + tpw_pkg::ACCW'(den >> 1);
      rem <= '0;
      dvs <= den;
    end else if (run) begin
      rem <= fits ? tpw_pkg::NW'(trial - {1'b0, dvs}) : trial[tpw_pkg::NW-1:0];
      sh  <= {sh[tpw_pkg::ACCW-2:0], fits};
    end
  end

endmodule

// File: hdl/tag_pose_to_world_error.sv
// ---------------------------------------------------------------------------
// tag_pose_to_world_error
// Rotates a tag position by the inverse quaternion, maps it to world axes and measures its error against odometry.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the item kind (0 odometry, 1 tag). An
//   odometry transfer stores the reference position and gives no result.
//   A tag transfer starts the sequencer; s_tready stays low until the
//   result is loaded into the output register.
//   A tag item runs through the product phase (issues and captures), the
//   norm, then per axis the multiply-accumulate and divider phases, and
//   the output load: m_tvalid rises and s_tready returns together. A zero
//   quaternion goes straight to the output load and gives its result with
//   the degenerate flag. The multiplier is a shared 34x17 unit and the
//   divider yields one quotient bit a cycle; one item is in flight at a time.
//   Output stream m_*: one transfer per tag item. If the receiver stalls, the
//   finished result waits in the sequencer until the output register frees.
//   Config port: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while idle. Unknown indexes are dropped.
//   Reset (rst, synchronous) restores register defaults, clears odometry
//   and drops any result in flight.
// ---------------------------------------------------------------------------
`include "tag_pose_to_world_error_assert.svh"

module tag_pose_to_world_error (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], quat_w, quat_i, quat_j, quat_k
  input  logic [159:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // world_x, world_y, world_z, error_x, error_y, error_z, zero pad
  output logic [191:0] m_tdata,
  // degenerate
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_NORM, S_MAC, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic [1:0] ax;
  logic       degen;

  logic [31:0] wall, depth, height;
  logic [31:0] odom_x, odom_y, odom_z;
  logic [31:0] vx, vy, vz;
  logic [15:0] qw, qi, qj, qk;
  logic [31:0] pr [tpw_pkg::NPROD];
  logic [tpw_pkg::NW-1:0] nrm;
  logic signed [tpw_pkg::RW-1:0] rx, ry, rz;

  tpw_pkg::mac_ctl_t ctl;
  logic signed [tpw_pkg::MW-1:0]   mac_a;
  logic signed [tpw_pkg::BW-1:0]   mac_b;
  logic signed [tpw_pkg::PRW-1:0]  prod;
  logic signed [tpw_pkg::ACCW-1:0] acc;
  logic        div_start, div_done;
  logic signed [tpw_pkg::RW-1:0]   quo;

  logic [15:0] op_a, op_b;
  logic [tpw_pkg::MW-1:0] e_ww, e_ii, e_jj, e_kk, e_ij, e_ik, e_jk, e_wi, e_wj, e_wk;
  logic [tpw_pkg::MW-1:0] m_ent;
  logic [31:0] v_sel;
  logic [1:0]  col;
  logic [31:0] wx, wy, wz;
  logic [tpw_pkg::EW-1:0] ex, ey, ez;
  logic        s_fire, out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign col       = cnt[2:1];

  // operand pair of each quaternion product
  always_comb begin
    unique case (cnt)
      tpw_pkg::P_WW: begin op_a = qw; op_b = qw; end
      tpw_pkg::P_II: begin op_a = qi; op_b = qi; end
      tpw_pkg::P_JJ: begin op_a = qj; op_b = qj; end
      tpw_pkg::P_KK: begin op_a = qk; op_b = qk; end
      tpw_pkg::P_IJ: begin op_a = qi; op_b = qj; end
      tpw_pkg::P_IK: begin op_a = qi; op_b = qk; end
      tpw_pkg::P_JK: begin op_a = qj; op_b = qk; end
      tpw_pkg::P_WI: begin op_a = qw; op_b = qi; end
      tpw_pkg::P_WJ: begin op_a = qw; op_b = qj; end
      tpw_pkg::P_WK: begin op_a = qw; op_b = qk; end
      default:       begin op_a = '0; op_b = '0; end
    endcase
  end

  // entries of the inverse rotation matrix, scaled by |q|^2
  always_comb begin
    e_ww = {{2{pr[tpw_pkg::P_WW][31]}}, pr[tpw_pkg::P_WW]};
    e_ii = {{2{pr[tpw_pkg::P_II][31]}}, pr[tpw_pkg::P_II]};
    e_jj = {{2{pr[tpw_pkg::P_JJ][31]}}, pr[tpw_pkg::P_JJ]};
    e_kk = {{2{pr[tpw_pkg::P_KK][31]}}, pr[tpw_pkg::P_KK]};
    e_ij = {{2{pr[tpw_pkg::P_IJ][31]}}, pr[tpw_pkg::P_IJ]};
    e_ik = {{2{pr[tpw_pkg::P_IK][31]}}, pr[tpw_pkg::P_IK]};
    e_jk = {{2{pr[tpw_pkg::P_JK][31]}}, pr[tpw_pkg::P_JK]};
    e_wi = {{2{pr[tpw_pkg::P_WI][31]}}, pr[tpw_pkg::P_WI]};
    e_wj = {{2{pr[tpw_pkg::P_WJ][31]}}, pr[tpw_pkg::P_WJ]};
    e_wk = {{2{pr[tpw_pkg::P_WK][31]}}, pr[tpw_pkg::P_WK]};
    unique case ({ax, col})
      4'b0000: m_ent = e_ww + e_ii - e_jj - e_kk;
      4'b0001: m_ent = (e_ij + e_wk) << 1;
      4'b0010: m_ent = (e_ik - e_wj) << 1;
      4'b0100: m_ent = (e_ij - e_wk) << 1;
      4'b0101: m_ent = e_ww - e_ii + e_jj - e_kk;
      4'b0110: m_ent = (e_jk + e_wi) << 1;
      4'b1000: m_ent = (e_ik + e_wj) << 1;
      4'b1001: m_ent = (e_jk - e_wi) << 1;
      4'b1010: m_ent = e_ww - e_ii - e_jj + e_kk;
      default: m_ent = '0;
    endcase
    unique case (col)
      2'd0:    v_sel = vx;
      2'd1:    v_sel = vy;
      default: v_sel = vz;
    endcase
  end

  // drive the shared multiplier
  always_comb begin
    ctl   = '0;
    mac_a = '0;
    mac_b = '0;
    if (state == S_PROD && cnt < 4'(tpw_pkg::NPROD)) begin
      mac_a = {{(tpw_pkg::MW-16){op_a[15]}}, op_a};
      mac_b = {op_b[15], op_b};
    end else if (state == S_MAC && cnt < 4'd6) begin
      ctl.issue = 1'b1;
      ctl.clr   = (cnt == 4'd0);
      ctl.shl   = cnt[0];
      mac_a     = m_ent;
      // high half signed, low half unsigned
      mac_b     = cnt[0] ? {v_sel[31], v_sel[31:16]} : {1'b0, v_sel[15:0]};
    end
  end

  assign div_start = (state == S_MAC) && (cnt == 4'd7);

  tpw_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .a    (mac_a),
    .b    (mac_b),
    .prod (prod),
    .acc  (acc)
  );

  tpw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (nrm),
    .done  (div_done),
    .quo   (quo)
  );

  // world mapping and error against odometry
  always_comb begin
    wx = tpw_pkg::sat32(43'($signed(wall)) + 43'(rz) - 43'($signed(depth)));
    wy = tpw_pkg::sat32(43'sd0 - 43'(ry));
    wz = tpw_pkg::sat32(43'($signed(height)) - 43'(rx));
    ex = tpw_pkg::abs_sat({odom_x[31], odom_x} - {wx[31], wx});
    ey = tpw_pkg::abs_sat({odom_y[31], odom_y} - {wy[31], wy});
    ez = tpw_pkg::abs_sat({odom_z[31], odom_z} - {wz[31], wz});
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wall   <= tpw_pkg::WALL_RESET;
      depth  <= tpw_pkg::DEPTH_RESET;
      height <= tpw_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpw_pkg::REG_WALL:   wall   <= cfg_data;
        tpw_pkg::REG_DEPTH:  depth  <= cfg_data;
        tpw_pkg::REG_HEIGHT: height <= cfg_data;
        default: ;
      endcase
    end
  end

  // product capture, in the cycle after its issue
  always_ff @(posedge clk) begin
    if (state == S_PROD && cnt != 4'd0) begin
      pr[cnt - 4'd1] <= prod[31:0];
    end
  end

  // sequencer with the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      ax       <= '0;
      degen    <= 1'b0;
      m_tvalid <= 1'b0;
      odom_x   <= '0;
      odom_y   <= '0;
      odom_z   <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (!s_tuser) begin
              odom_x <= s_tdata[31:0];
              odom_y <= s_tdata[63:32];
              odom_z <= s_tdata[95:64];
            end else begin
              vx    <= s_tdata[31:0];
              vy    <= s_tdata[63:32];
              vz    <= s_tdata[95:64];
              qw    <= s_tdata[111:96];
              qi    <= s_tdata[127:112];
              qj    <= s_tdata[143:128];
              qk    <= s_tdata[159:144];
              degen <= (s_tdata[159:96] == '0);
              cnt   <= '0;
              ax    <= '0;
              state <= (s_tdata[159:96] == '0) ? S_FIN : S_PROD;
            end
          end
        end
        S_PROD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(tpw_pkg::NPROD)) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          nrm   <= tpw_pkg::NW'(pr[tpw_pkg::P_WW]) + tpw_pkg::NW'(pr[tpw_pkg::P_II])
                 + tpw_pkg::NW'(pr[tpw_pkg::P_JJ]) + tpw_pkg::NW'(pr[tpw_pkg::P_KK]);
          cnt   <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd7) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (ax)
              2'd0:    rx <= quo;
              2'd1:    ry <= quo;
              default: rz <= quo;
            endcase
            cnt <= '0;
            if (ax == 2'd2) begin
              state <= S_FIN;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_MAC;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= degen;
            if (degen) begin
              m_tdata <= '0;
            end else begin
              m_tdata <= {3'b000, ez, ey, ex, wz, wy, wx};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TPW_ASSERT_ALWAYS(a_degen_zero, clk, rst, !(m_tvalid && m_tuser) || (m_tdata == '0))
  `TPW_ASSERT_NEXT(a_tag_busy, clk, rst, s_tvalid && s_tready && s_tuser, !s_tready)
  `TPW_ASSERT_NEXT(a_odom_silent, clk, rst, s_fire && !s_tuser && !m_tvalid, !m_tvalid)

endmodule

// File: dv/tb_tag_pose_to_world_error.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tag_pose_to_world_error
// Self-checking bench: drives odometry and tag transfers with random gaps,
// predicts each world position and error from its own fixed-point model and
// compares every output transfer field by field.
// ---------------------------------------------------------------------------
module tb_tag_pose_to_world_error;

  localparam logic       OP_ODOM    = 1'b0;
  localparam logic       OP_TAG     = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;   // no register behind this index
  localparam int         SETTLE     = 300;    // idle wait after the last owed result
  localparam int         STALL_MAX  = 5000;   // cycles without any transfer
  localparam int         N_RANDOM   = 1600;

  typedef struct {
    logic [31:0]            wx, wy, wz;
    logic [tpw_pkg::EW-1:0] ex, ey, ez;
    logic                   degen;
  } world_fix_t;

  // Tracks offsets and odometry, and holds the world fixes still owed.
  class world_fix_board;
    logic signed [31:0] wall, depth, height;
    logic signed [31:0] odom_x, odom_y, odom_z;
    world_fix_t         owed[$];
    int                 errors;

    function void clear_state();
      wall   = tpw_pkg::WALL_RESET;
      depth  = tpw_pkg::DEPTH_RESET;
      height = tpw_pkg::HEIGHT_RESET;
      odom_x = 0;
      odom_y = 0;
      odom_z = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        tpw_pkg::REG_WALL:   wall   = val;
        tpw_pkg::REG_DEPTH:  depth  = val;
        tpw_pkg::REG_HEIGHT: height = val;
        default: ;
      endcase
    endfunction

    // rounded quotient, halves away from zero, magnitude clamped to 2^40
    function logic signed [127:0] round_div(logic signed [127:0] num,
                                            logic signed [127:0] n);
      logic                 neg;
      logic signed [127:0] mag;
      neg = num < 0;
      mag = neg ? -num : num;
      mag = (mag + (n >>> 1)) / n;
      if (mag > (128'sd1 <<< 40)) mag = 128'sd1 <<< 40;
      return neg ? -mag : mag;
    endfunction

    function logic [31:0] clip32(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -128'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function logic [tpw_pkg::EW-1:0] distance(logic signed [31:0] odom,
                                              logic [31:0] world);
      logic signed [127:0] d;
      d = 128'(odom) - 128'($signed(world));
      if (d < 0) d = -d;
      if (d > 128'sh7FFF_FFFF) d = 128'sh7FFF_FFFF;
      return d[tpw_pkg::EW-1:0];
    endfunction

    function void note_input(logic op, logic [159:0] data);
      logic signed [127:0] x, y, z, w, i, j, k, n, c0, d, cx, cy, cz, rx, ry, rz;
      world_fix_t e;
      x = $signed(data[31:0]);
      y = $signed(data[63:32]);
      z = $signed(data[95:64]);
      if (op == OP_ODOM) begin
        odom_x = x[31:0];
        odom_y = y[31:0];
        odom_z = z[31:0];
        return;
      end
      w = $signed(data[111:96]);
      i = $signed(data[127:112]);
      j = $signed(data[143:128]);
      k = $signed(data[159:144]);
      n = w*w + i*i + j*j + k*k;
      e = '{default: 0};
      if (n == 0) begin
        e.degen = 1'b1;
        owed = {owed, e};
        return;
      end
      c0 = w*w - (i*i + j*j + k*k);
      d  = 2 * (i*x + j*y + k*z);
      cx = 2 * (j*z - k*y);
      cy = 2 * (k*x - i*z);
      cz = 2 * (i*y - j*x);
      rx = round_div(c0*x + d*i - cx*w, n);
      ry = round_div(c0*y + d*j - cy*w, n);
      rz = round_div(c0*z + d*k - cz*w, n);
      e.wx = clip32(128'(wall) + rz - 128'(depth));
      e.wy = clip32(-ry);
      e.wz = clip32(128'(height) - rx);
      e.ex = distance(odom_x, e.wx);
      e.ey = distance(odom_y, e.wy);
      e.ez = distance(odom_z, e.wz);
      owed = {owed, e};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(logic [191:0] data, logic degen);
      world_fix_t e;
      if (owed.size() == 0) begin
        report("unexpected result", data[31:0], 32'd0);
        return;
      end
      e = owed.pop_front();
      if (data[31:0]    !== e.wx) report("world_x", data[31:0], e.wx);
      if (data[63:32]   !== e.wy) report("world_y", data[63:32], e.wy);
      if (data[95:64]   !== e.wz) report("world_z", data[95:64], e.wz);
      if (data[126:96]  !== e.ex) report("error_x", 32'(data[126:96]), 32'(e.ex));
      if (data[157:127] !== e.ey) report("error_y", 32'(data[157:127]), 32'(e.ey));
      if (data[188:158] !== e.ez) report("error_z", 32'(data[188:158]), 32'(e.ez));
      if (degen !== e.degen) report("degenerate", 32'(degen), 32'(e.degen));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  world_fix_board board = new();
  bit             busy_mode;   // when clear, neither side idles
  int             quiet_cycles;

  tag_pose_to_world_error dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, sometimes long ones.
  function int gap_len();
    int r;
    if (!busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Predict on the input transfer, check on the output transfer.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_input(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tuser);
  end

  // Receiver: hold ready for a while, then drop it for a random stall.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task send(logic op, logic [31:0] px, py, pz, logic [15:0] qw, qi, qj, qk);
    int g;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {qk, qj, qi, qw, pz, py, px};
    do @(posedge clk); while (!s_tready);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // Drain all owed results, then let a trailing odometry transfer settle.
  task drain();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [15:0] rand_quat_part();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($signed($urandom_range(0, 32768)) - 16384);  // near unit
    if (r < 6) return 16'($signed($urandom_range(0, 6)) - 3);          // tiny norm
    return 16'($urandom());
  endfunction

  function logic [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
    return $urandom();
  endfunction

  task random_items(int count);
    logic [15:0] qw, qi, qj, qk;
    repeat (count) begin
      qw = rand_quat_part();
      qi = rand_quat_part();
      qj = rand_quat_part();
      qk = rand_quat_part();
      if ($urandom_range(0, 49) == 0) {qw, qi, qj, qk} = '0;
      send($urandom_range(0, 3) == 0 ? OP_ODOM : OP_TAG,
           rand_pos(), rand_pos(), rand_pos(), qw, qi, qj, qk);
    end
  endtask

  initial begin
    board.clear_state();
    busy_mode = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, both kinds, zero quaternion, tiny norms.
    send(OP_TAG, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         16'h4000, 16'h0, 16'h0, 16'h0);
    send(OP_TAG, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         16'h0, 16'h0, 16'h0, 16'h0);
    send(OP_ODOM, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
         16'h8000, 16'h0, 16'h0, 16'h0);
    send(OP_TAG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         16'h4000, 16'h0, 16'h0, 16'h0);
    send(OP_TAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         16'h4000, 16'h0, 16'h0, 16'h0);
    send(OP_TAG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
         16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send(OP_TAG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send(OP_TAG, 32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0001, 16'h0, 16'h0);
    send(OP_TAG, 32'h0001_0000, 32'h0001_0000, 32'h0,
         16'h0, 16'h0, 16'h0001, 16'h0001);
    send(OP_TAG, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
         16'h0001, 16'hFFFF, 16'h0, 16'h0);
    send(OP_TAG, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0003,
         16'h2D41, 16'h2D41, 16'h0, 16'h0);
    send(OP_TAG, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send(OP_ODOM, 32'h0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_TAG, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
         16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC);
    send(OP_TAG, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();

    // Phase 1: reset defaults, with and without idling.
    random_items(N_RANDOM / 4);
    busy_mode = 1'b0;
    random_items(N_RANDOM / 8);
    drain();

    // Phase 2: offsets at the positive and negative extremes.
    busy_mode = 1'b1;
    write_reg(tpw_pkg::REG_WALL, 32'h7FFF_FFFF);
    write_reg(tpw_pkg::REG_DEPTH, 32'h8000_0000);
    write_reg(tpw_pkg::REG_HEIGHT, 32'h8000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    random_items(N_RANDOM / 4);
    drain();

    // Phase 3: reversed extremes.
    write_reg(tpw_pkg::REG_WALL, 32'h8000_0000);
    write_reg(tpw_pkg::REG_DEPTH, 32'h7FFF_FFFF);
    write_reg(tpw_pkg::REG_HEIGHT, 32'h7FFF_FFFF);
    random_items(N_RANDOM / 8);
    drain();

    // Phase 4: random wall and depth offsets, height zero.
    write_reg(tpw_pkg::REG_WALL, $urandom());
    write_reg(tpw_pkg::REG_DEPTH, $urandom());
    write_reg(tpw_pkg::REG_HEIGHT, 32'h0);
    random_items(N_RANDOM / 4);
    drain();

    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
